### rtl/core/midi_file_track_parser_unit_defines.svh
`ifndef MIDI_FILE_TRACK_PARSER_UNIT_DEFINES_SVH
`define MIDI_FILE_TRACK_PARSER_UNIT_DEFINES_SVH

// clocked assertion, off while reset is held
`define MFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/mfp_pkg.sv
package mfp_pkg;

    typedef struct packed {
        logic [7:0] track_byte;
        logic       last_in_track;
        logic       new_track;
    } mfp_in_t;

    typedef struct packed {
        logic [7:0]  midi_byte;
        logic [47:0] event_time_us;
        logic        last_of_event;
        logic        track_ended;
    } mfp_out_t;

    // one queue entry per accepted track byte
    typedef struct packed {
        logic        restart;
        logic        add_en;
        logic        tempo_en;
        logic [31:0] value;
        logic [1:0]  n_emit;
        logic        end_last;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
    } mfp_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mfp_q_stat_t;

    localparam logic [7:0]  ST_META      = 8'hFF;
    localparam logic [7:0]  META_TEMPO   = 8'h51;
    localparam logic [7:0]  META_END     = 8'h2F;
    localparam logic [7:0]  ST_SYSEX     = 8'hF0;
    localparam logic [7:0]  ST_ESCAPE    = 8'hF7;
    localparam logic [3:0]  HI_PROG      = 4'hC;
    localparam logic [3:0]  HI_PRESS     = 4'hD;
    localparam logic [23:0] TEMPO_RESET  = 24'd500000;
    localparam logic [15:0] DIV_DEFAULT  = 16'd96;
    localparam logic [23:0] TICK_RESET   = 24'd5208;
    localparam logic [2:0]  ADDR_TPQ     = 3'd0;

endpackage

### rtl/core/mfp_div.sv
module mfp_div
    import mfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [23:0] quotient
);
    logic [23:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] rem_sh;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[15:0], q_reg[23]};
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring step, quotient bits shift in where dividend bits leave
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[22:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

### rtl/core/mfp_queue.sv
module mfp_queue
    import mfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  mfp_op_t     din,
    input  logic        pop,
    output mfp_op_t     dout,
    output mfp_q_stat_t stat
);
    localparam int DEPTH = 4;

    mfp_op_t    mem_reg [DEPTH];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb begin
        wp_next  = wp_reg + 2'(push);
        rp_next  = rp_reg + 2'(pop);
        cnt_next = cnt_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= din;
        end
    end

    assign dout       = mem_reg[rp_reg];
    assign stat.full  = (cnt_reg == 3'(DEPTH));
    assign stat.empty = (cnt_reg == 3'd0);
endmodule

### rtl/core/mfp_front.sv
module mfp_front
    import mfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  mfp_in_t in_data,
    output mfp_op_t op
);
    typedef enum logic [8:0] {
        PH_DELTA     = 9'b000000001,
        PH_STATUS    = 9'b000000010,
        PH_META_TYPE = 9'b000000100,
        PH_META_LEN  = 9'b000001000,
        PH_META_DATA = 9'b000010000,
        PH_SYX_LEN   = 9'b000100000,
        PH_SYX_DATA  = 9'b001000000,
        PH_DATA1     = 9'b010000000,
        PH_DATA2     = 9'b100000000
    } phase_t;

    phase_t      ph_reg, ph_next, ph;
    logic [31:0] acc_reg, acc_next, acc, vlq;
    logic [31:0] left_reg, left_next, left;
    logic [7:0]  rs_reg, rs_next, rs;
    logic [7:0]  cs_reg, cs_next, cs;
    logic [7:0]  mk_reg, mk_next, mk;
    logic        fin_reg, fin_next, fin;
    logic [7:0]  b;
    logic [1:0]  n;
    logic        two;

    always_comb begin
        b  = in_data.track_byte;
        ph = ph_reg; acc = acc_reg; left = left_reg;
        rs = rs_reg; cs = cs_reg; mk = mk_reg; fin = fin_reg;
        if (in_data.new_track) begin
            ph = PH_DELTA; acc = '0; left = '0;
            rs = '0; cs = '0; mk = '0; fin = 1'b0;
        end
        op          = '0;
        op.restart  = in_data.new_track;
        n           = 2'd0;
        vlq         = {acc[24:0], b[6:0]};
        two         = (cs[7:4] != HI_PROG) && (cs[7:4] != HI_PRESS);
        ph_next = ph; acc_next = acc; left_next = left;
        rs_next = rs; cs_next = cs; mk_next = mk; fin_next = fin;

        if (!fin) begin
            unique case (ph)
                PH_DELTA: begin
                    acc_next = vlq;
                    if (!b[7]) begin
                        op.add_en = 1'b1;
                        op.value  = vlq;
                        acc_next  = '0;
                        ph_next   = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b[7]) begin
                        if (b == ST_META) begin
                            rs_next = '0;
                            ph_next = PH_META_TYPE;
                        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                            rs_next = '0;
                            if (b == ST_SYSEX) begin
                                op.b0 = ST_SYSEX;
                                n     = 2'd1;
                            end
                            acc_next = '0;
                            ph_next  = PH_SYX_LEN;
                        end else begin
                            rs_next = b;
                            cs_next = b;
                            ph_next = PH_DATA1;
                        end
                    end else if (rs != 8'd0) begin
                        // running status: the stored status leads the data byte
                        cs_next = rs;
                        op.b0   = rs;
                        op.b1   = b;
                        n       = 2'd2;
                        ph_next = ((rs[7:4] != HI_PROG) && (rs[7:4] != HI_PRESS))
                                  ? PH_DATA2 : PH_DELTA;
                    end
                end
                PH_DATA1: begin
                    op.b0   = cs;
                    op.b1   = b;
                    n       = 2'd2;
                    ph_next = two ? PH_DATA2 : PH_DELTA;
                end
                PH_DATA2: begin
                    op.b0   = b;
                    n       = 2'd1;
                    ph_next = PH_DELTA;
                end
                PH_META_TYPE: begin
                    mk_next  = b;
                    acc_next = '0;
                    ph_next  = PH_META_LEN;
                end
                PH_META_LEN: begin
                    acc_next = vlq;
                    if (!b[7]) begin
                        left_next = vlq;
                        acc_next  = '0;
                        if (mk == META_END) begin
                            op.b0       = 8'd0;
                            op.end_last = 1'b1;
                            n           = 2'd1;
                            fin_next    = 1'b1;
                        end else begin
                            if (mk == META_TEMPO && vlq != 32'd3) begin
                                mk_next = '0;
                            end
                            ph_next = (vlq != 32'd0) ? PH_META_DATA : PH_DELTA;
                        end
                    end
                end
                PH_META_DATA: begin
                    acc_next  = {acc[23:0], b};
                    left_next = left - 32'd1;
                    if (left == 32'd1) begin
                        if (mk == META_TEMPO) begin
                            op.tempo_en = 1'b1;
                            op.value    = {acc[23:0], b};
                        end
                        acc_next = '0;
                        ph_next  = PH_DELTA;
                    end
                end
                PH_SYX_LEN: begin
                    acc_next = vlq;
                    if (!b[7]) begin
                        left_next = vlq;
                        acc_next  = '0;
                        ph_next   = (vlq != 32'd0) ? PH_SYX_DATA : PH_DELTA;
                    end
                end
                PH_SYX_DATA: begin
                    op.b0     = b;
                    n         = 2'd1;
                    left_next = left - 32'd1;
                    if (left == 32'd1) begin
                        ph_next = PH_DELTA;
                    end
                end
                default: ph_next = PH_DELTA;
            endcase

            if (in_data.last_in_track && !fin_next) begin
                case (n)
                    2'd0:    op.b0 = 8'd0;
                    2'd1:    op.b1 = 8'd0;
                    default: op.b2 = 8'd0;
                endcase
                n           = n + 2'd1;
                op.end_last = 1'b1;
                fin_next    = 1'b1;
            end
        end
        op.n_emit = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_DELTA;
            acc_reg  <= '0;
            left_reg <= '0;
            rs_reg   <= '0;
            cs_reg   <= '0;
            mk_reg   <= '0;
            fin_reg  <= 1'b0;
        end else if (accept) begin
            ph_reg   <= ph_next;
            acc_reg  <= acc_next;
            left_reg <= left_next;
            rs_reg   <= rs_next;
            cs_reg   <= cs_next;
            mk_reg   <= mk_next;
            fin_reg  <= fin_next;
        end
    end
endmodule

### rtl/core/mfp_back.sv
module mfp_back
    import mfp_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  logic [15:0] ticks,
    input  mfp_op_t     q_data,
    input  mfp_q_stat_t q_stat,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output mfp_out_t    m_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_ACC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t               st_reg, st_next;
    mfp_op_t              cur_reg, cur_next;
    logic [1:0]           idx_reg, idx_next;
    logic [23:0]          tempo_reg, tempo_next;
    logic [23:0]          upt_reg, upt_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [55:0]          prod_reg;
    logic                 prod_load;
    logic                 mv_reg, mv_next;
    logic                 cfg_pend_reg, cfg_pend_next;
    mfp_out_t             md_reg, md_next;
    logic                 div_start, div_done;
    logic [23:0]          div_q;
    logic [15:0]          divisor;
    logic [63:0]          time64;
    logic [7:0]           slot;

    assign divisor = (ticks == 16'd0) ? DIV_DEFAULT : ticks;
    assign time64  = 64'(time_reg);

    mfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tempo_next),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        st_next       = st_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        tempo_next    = tempo_reg;
        upt_next      = upt_reg;
        time_next     = time_reg;
        prod_load     = 1'b0;
        div_start     = 1'b0;
        q_pop         = 1'b0;
        mv_next       = mv_reg && !m_ready;
        md_next       = md_reg;
        cfg_pend_next = cfg_pend_reg || cfg_wr;
        case (idx_reg)
            2'd0:    slot = cur_reg.b0;
            2'd1:    slot = cur_reg.b1;
            default: slot = cur_reg.b2;
        endcase

        unique case (st_reg)
            S_IDLE: begin
                if (cfg_wr || cfg_pend_reg) begin
                    // a division write seen while busy is recomputed here
                    div_start     = 1'b1;
                    cfg_pend_next = 1'b0;
                    cur_next      = '0;
                    st_next       = S_DIV;
                end else if (!q_stat.empty) begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    idx_next = '0;
                    st_next  = S_PREP;
                end
            end
            S_PREP: begin
                if (cur_reg.restart) begin
                    cur_next.restart = 1'b0;
                    tempo_next       = TEMPO_RESET;
                    time_next        = '0;
                    div_start        = 1'b1;
                    st_next          = S_DIV;
                end else if (cur_reg.add_en) begin
                    cur_next.add_en = 1'b0;
                    prod_load       = 1'b1;
                    st_next         = S_ACC;
                end else if (cur_reg.tempo_en) begin
                    cur_next.tempo_en = 1'b0;
                    tempo_next        = cur_reg.value[23:0];
                    div_start         = 1'b1;
                    st_next           = S_DIV;
                end else if (cur_reg.n_emit != 2'd0) begin
                    st_next = S_EMIT;
                end else begin
                    st_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    upt_next = div_q;
                    st_next  = (cur_reg.n_emit == 2'd0 && !cur_reg.add_en &&
                                !cur_reg.tempo_en && !cur_reg.restart) ? S_IDLE : S_PREP;
                end
            end
            S_ACC: begin
                time_next = time_reg + TIME_BITS'(prod_reg);
                st_next   = S_PREP;
            end
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next              = 1'b1;
                    md_next.midi_byte    = slot;
                    md_next.event_time_us = time64[47:0];
                    md_next.last_of_event = (idx_reg + 2'd1 == cur_reg.n_emit);
                    md_next.track_ended  = (idx_reg + 2'd1 == cur_reg.n_emit) &&
                                           cur_reg.end_last;
                    idx_next             = idx_reg + 2'd1;
                    if (idx_reg + 2'd1 == cur_reg.n_emit) begin
                        st_next = S_IDLE;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            cur_reg      <= '0;
            idx_reg      <= '0;
            tempo_reg    <= TEMPO_RESET;
            upt_reg      <= TICK_RESET;
            time_reg     <= '0;
            mv_reg       <= 1'b0;
            cfg_pend_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            cur_reg      <= cur_next;
            idx_reg      <= idx_next;
            tempo_reg    <= tempo_next;
            upt_reg      <= upt_next;
            time_reg     <= time_next;
            mv_reg       <= mv_next;
            cfg_pend_reg <= cfg_pend_next;
        end
        md_reg <= md_next;
        if (prod_load) begin
            prod_reg <= 56'(cur_reg.value) * 56'(upt_reg);
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;
endmodule

### rtl/core/midi_file_track_parser_unit.sv
// Standard MIDI file track parser. The front takes one track byte per cycle into a
// four-entry queue whenever the queue has room, so bytes stream at one a cycle in
// bursts. The back drains one queue entry per byte: it pops the entry in idle, steps
// through it in a prepare state, emits each MIDI result as the output takes it, adds
// a completed delta time by a 32x24 multiply and then the 48-bit add, and for a tempo
// change, a new track or a write of ticks_per_quarter runs the serial 24-bit divider
// that sets us per tick. The sustained rate for ordinary event data is therefore set
// by the back.
module midi_file_track_parser_unit
    import mfp_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mfp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output mfp_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] tpq_reg;
    logic        cfg_wr;
    logic        accept;
    logic        q_pop;
    mfp_op_t     op_in, op_out;
    mfp_q_stat_t q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TPQ);
    assign prdata = (paddr == ADDR_TPQ) ? {16'd0, tpq_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpq_reg <= DIV_DEFAULT;
        end else if (cfg_wr) begin
            tpq_reg <= pwdata[15:0];
        end
    end

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    mfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .op      (op_in)
    );

    mfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .din     (op_in),
        .pop     (q_pop),
        .dout    (op_out),
        .stat    (q_stat)
    );

    // the divider takes the new division straight from pwdata during the write, before tpq_reg updates
    mfp_back #(.TIME_BITS(TIME_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .ticks   (cfg_wr ? pwdata[15:0] : tpq_reg),
        .q_data  (op_out),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

### rtl/core/mfp_checker.sv
`include "midi_file_track_parser_unit_defines.svh"

module mfp_checker
    import mfp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input mfp_out_t m_data,
    input logic     pready
);
    `MFP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped while stalled")
    `MFP_ASSERT(a_end_byte, m_valid && m_data.track_ended |-> m_data.midi_byte == 8'd0, "end result carries a byte")
    `MFP_ASSERT(a_end_last, m_valid && m_data.track_ended |-> m_data.last_of_event, "end result not last of event")
    `MFP_ASSERT_ALWAYS(a_pready, pready, "pready low")
endmodule

bind midi_file_track_parser_unit mfp_checker u_mfp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
